// File: rtl/core/pli_pkg.sv
package pli_pkg;

  // Fixed beat field widths
  localparam int KIND_W  = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 16;
  localparam int ST_W    = 2;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int MAX_RESULTS = 16;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

  // Response status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

  // Cell chain operations
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

endpackage

// File: rtl/core/pli_req_if.sv
interface pli_req_if;
  logic                        valid;
  logic                        ready;
  logic [pli_pkg::KIND_W-1:0]  kind;
  logic [pli_pkg::POS_W-1:0]   position;
  logic [pli_pkg::VAL_W-1:0]   value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

// File: rtl/core/pli_rsp_if.sv
interface pli_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pli_pkg::ST_W-1:0]   status;
  logic [pli_pkg::VAL_W-1:0]  element;
  logic [pli_pkg::IDX_W-1:0]  index;
  logic [pli_pkg::CNT_W-1:0]  count;
  logic                       last;

  modport source (output valid, status, element, index, count, last, input ready);
  modport sink   (input valid, status, element, index, count, last, output ready);
endinterface

// File: rtl/core/pli_cell.sv
module pli_cell #(
  parameter int IDX    = 0,
  parameter int EW     = 16,
  parameter int PW     = 5,
  parameter int CW     = 5
) (
  input  logic                        clk,
  input  logic [pli_pkg::OP_W-1:0]    op,
  input  logic [PW-1:0]               pos,
  input  logic [CW-1:0]               cnt,
  input  logic [EW-1:0]               value,
  input  logic [EW-1:0]               left,
  input  logic [EW-1:0]               right,
  input  logic [EW-1:0]               first,
  output logic [EW-1:0]               data
);
  import pli_pkg::*;

  localparam logic [PW-1:0] IDX_P = PW'(IDX);

  logic [EW-1:0] data_next;

  // Per-cell select: neighbour, new value, wrap-around or hold
  always_comb begin
    data_next = data;
    case (op)
      OP_INSERT: begin
        if (IDX_P > pos) begin
          data_next = left;
        end else if (IDX_P == pos) begin
          data_next = value;
        end
      end
      OP_ERASE: begin
        if (IDX_P >= pos) begin
          data_next = right;
        end
      end
      OP_ROTATE: begin
        if (int'(cnt) == IDX + 1) begin
          data_next = first;
        end else if (int'(cnt) > IDX + 1) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: rtl/core/positional_list_insert_erase_top.sv
// Channel  Dir  Beat fields                              Role
// req      in   kind, position, value                    one operation per beat
// rsp      out  status, element, index, count, last      one result per beat
//
// Insert and erase: the result is registered in the cycle after acceptance.
// List-out: after the request is taken, one entry per cycle while rsp is not stalled,
// as the cell ring rotates; the ring turns a full lap to restore order.
// rsp back-pressure freezes the ring; req.ready is low while a list-out runs.
// Synchronous reset empties the list; cell contents are not cleared.
module positional_list_insert_erase_top #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  pli_req_if.sink     req,
  pli_rsp_if.source   rsp
);
  import pli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [CW-1:0]         step;
  logic [OP_W-1:0]       cell_op;
  logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] new_val;

  logic                  out_free;
  logic                  accept;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic                  step_last;
  logic                  step_emit;

  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = !busy && out_free;
  assign accept   = req.valid && req.ready;
  assign pos_x    = PW'(req.position);
  assign cnt_x    = PW'(cnt);
  assign new_val  = ELEMENT_WIDTH'(req.value);
  assign step_emit = int'(step) < MAX_RESULTS;
  assign step_last = ({1'b0, step} + 1'b1 == {1'b0, cnt}) ||
                     (int'(step) == MAX_RESULTS - 1);

  // Chain operation for this cycle
  always_comb begin
    cell_op = OP_HOLD;
    if (busy && out_free) begin
      cell_op = OP_ROTATE;
    end else if (accept) begin
      case (req.kind)
        KIND_INSERT: begin
          if (cnt != CAP_C && pos_x <= cnt_x) begin
            cell_op = OP_INSERT;
          end
        end
        KIND_ERASE: begin
          if (cnt != '0 && pos_x < cnt_x) begin
            cell_op = OP_ERASE;
          end
        end
        default: cell_op = OP_HOLD;
      endcase
    end
  end

  // Row of storage cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == CAPACITY - 1) ? i : i + 1;
    pli_cell #(
      .IDX (i),
      .EW  (ELEMENT_WIDTH),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .pos   (pos_x),
      .cnt   (cnt),
      .value (new_val),
      .left  (cell_data[LI]),
      .right (cell_data[RI]),
      .first (cell_data[0]),
      .data  (cell_data[i])
    );
  end

  // Control: count, list-out sequencing and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      busy      <= 1'b0;
      step      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_free) begin
        rsp.valid <= 1'b0;
      end
      if (busy && out_free) begin
        if (step_emit) begin
          rsp.valid <= 1'b1;
        end
        step <= step + 1'b1;
        if ({1'b0, step} + 1'b1 == {1'b0, cnt}) begin
          busy <= 1'b0;
        end
      end else if (accept) begin
        case (req.kind)
          KIND_INSERT: begin
            rsp.valid <= 1'b1;
            if (cell_op == OP_INSERT) begin
              cnt <= cnt + 1'b1;
            end
          end
          KIND_ERASE: begin
            rsp.valid <= 1'b1;
            if (cell_op == OP_ERASE) begin
              cnt <= cnt - 1'b1;
            end
          end
          KIND_LIST: begin
            if (cnt == '0) begin
              rsp.valid <= 1'b1;
            end else begin
              busy <= 1'b1;
              step <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      if (step_emit) begin
        rsp.status  <= ST_OK;
        rsp.element <= VAL_W'(cell_data[0]);
        rsp.index   <= IDX_W'(step);
        rsp.count   <= CNT_W'(cnt);
        rsp.last    <= step_last;
      end
    end else if (accept) begin
      rsp.element <= '0;
      rsp.index   <= '0;
      rsp.last    <= 1'b1;
      case (req.kind)
        KIND_INSERT: begin
          if (cnt == CAP_C) begin
            rsp.status <= ST_FULL;
            rsp.count  <= CNT_W'(cnt);
          end else if (pos_x > cnt_x) begin
            rsp.status <= ST_BADPOS;
            rsp.count  <= CNT_W'(cnt);
          end else begin
            rsp.status <= ST_OK;
            rsp.count  <= CNT_W'(cnt + 1'b1);
          end
        end
        KIND_ERASE: begin
          if (cnt == '0) begin
            rsp.status <= ST_EMPTY;
            rsp.count  <= CNT_W'(cnt);
          end else if (pos_x >= cnt_x) begin
            rsp.status <= ST_BADPOS;
            rsp.count  <= CNT_W'(cnt);
          end else begin
            rsp.status <= ST_OK;
            rsp.count  <= CNT_W'(cnt - 1'b1);
          end
        end
        default: begin
          rsp.status <= ST_EMPTY;
          rsp.count  <= CNT_W'(cnt);
        end
      endcase
    end
  end

endmodule

// File: rtl/core/pli_checker.sv
module pli_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [pli_pkg::ST_W-1:0]    rsp_status,
  input logic [pli_pkg::VAL_W-1:0]   rsp_element,
  input logic [pli_pkg::IDX_W-1:0]   rsp_index,
  input logic [pli_pkg::CNT_W-1:0]   rsp_count,
  input logic                        rsp_last
);
  import pli_pkg::*;

  // Stalled beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_element) && $stable(rsp_index) && $stable(rsp_count) &&
      $stable(rsp_last))
    else $error("rsp beat changed while stalled");

  // Only list-out beats may be non-final, and those are all ok
  a_nonlast_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ST_OK)
    else $error("non-final beat with error status");

  // An error beat is a single, zeroed beat
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |->
      rsp_last && rsp_element == '0 && rsp_index == '0)
    else $error("error beat not single or not zeroed");

  // No new request while a list-out is still streaming
  a_no_req_mid_list: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("request taken during list-out");

endmodule

bind positional_list_insert_erase_top pli_checker u_pli_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_element (rsp.element),
  .rsp_index   (rsp.index),
  .rsp_count   (rsp.count),
  .rsp_last    (rsp.last)
);
